### rtl/miller_rabin_prime_test_unit_macros.svh
// Assertion macros for the prime test unit
`ifndef MILLER_RABIN_PRIME_TEST_UNIT_MACROS_SVH
`define MILLER_RABIN_PRIME_TEST_UNIT_MACROS_SVH

// Check that an antecedent implies a consequent in the next cycle
`define MR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define MR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/mrpt_pkg.sv
`timescale 1ns / 1ps
package mrpt_pkg;
    localparam int LIST_LEN = 13;

    function automatic logic [5:0] witness(input logic [3:0] idx);
        logic [5:0] w;
        begin
            case (idx)
                4'd0: w = 6'd2;
                4'd1: w = 6'd3;
                4'd2: w = 6'd5;
                4'd3: w = 6'd7;
                4'd4: w = 6'd11;
                4'd5: w = 6'd13;
                4'd6: w = 6'd17;
                4'd7: w = 6'd19;
                4'd8: w = 6'd23;
                4'd9: w = 6'd29;
                4'd10: w = 6'd31;
                4'd11: w = 6'd37;
                default: w = 6'd41;
            endcase
            return w;
        end
    endfunction
endpackage

### rtl/miller_rabin_prime_test_unit.sv
`timescale 1ns / 1ps
// Deterministic Miller-Rabin primality test unit.
// Input channel: candidate with in_valid / in_stall. The unit raises in_stall
// from the cycle after an item is accepted until its result is taken.
// Output channel: is_prime with out_valid / out_stall; one result per item.
// 0, 1, 2 and even numbers need no multiplication. For odd n each witness
// takes about log2(d) + popcount(d) + r modular multiplications,
// all on one shift-and-add mod unit.
// Throughput: one item at a time; the next item is accepted once the result
// has been taken.
// Reset clears the sequencer and drops any item in flight; no result is
// pending afterwards.
// A stalled result holds is_prime and out_valid until the receiver takes it.
// Only the low NUMBER_WIDTH bits of candidate are tested. WITNESS_COUNT
// selects how many witnesses, from 2 upward, are used.
`include "miller_rabin_prime_test_unit_macros.svh"
module miller_rabin_prime_test_unit #(
    parameter int NUMBER_WIDTH  = 64,
    parameter int WITNESS_COUNT = 13
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] candidate,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        is_prime
);
    localparam int W  = NUMBER_WIDTH;
    localparam int WC = (WITNESS_COUNT > mrpt_pkg::LIST_LEN) ? mrpt_pkg::LIST_LEN
                                                             : WITNESS_COUNT;
    localparam int RW = $clog2(W + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SPLIT  = 4'd1;
    localparam logic [3:0] S_WIT    = 4'd2;
    localparam logic [3:0] S_PSTEP  = 4'd3;
    localparam logic [3:0] S_PMUL   = 4'd4;
    localparam logic [3:0] S_PSQ    = 4'd5;
    localparam logic [3:0] S_CHK    = 4'd6;
    localparam logic [3:0] S_SQ     = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;
    localparam logic [3:0] S_PMULW  = 4'd9;
    localparam logic [3:0] S_PSQW   = 4'd10;
    localparam logic [3:0] S_SQW    = 4'd11;

    logic [3:0]   state_reg, state_next;
    logic [W-1:0] n_reg, n_next;
    logic [W-1:0] d_reg, d_next;
    logic [W-1:0] e_reg, e_next;
    logic [W-1:0] b_reg, b_next;
    logic [W-1:0] v_reg, v_next;
    logic [RW-1:0] r_reg, r_next;
    logic [RW-1:0] i_reg, i_next;
    logic [3:0]   k_reg, k_next;
    logic         res_reg, res_next;

    logic         mul_start;
    logic [W-1:0] mul_x, mul_y;
    logic [W-1:0] mul_prod;
    logic         mul_busy;
    logic         mul_done;
    logic [W-1:0] w_ext;
    logic [W-1:0] n_in;

    assign n_in  = candidate[W-1:0];
    assign w_ext = W'(mrpt_pkg::witness(k_reg));

    mrpt_mulmod #(.W(W)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .x     (mul_x),
        .y     (mul_y),
        .m     (n_reg),
        .busy  (mul_busy),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        b_next     = b_reg;
        v_next     = v_reg;
        r_next     = r_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        res_next   = res_reg;
        mul_start  = 1'b0;
        mul_x      = v_reg;
        mul_y      = b_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    n_next = n_in;
                    d_next = n_in - W'(1);
                    r_next = '0;
                    k_next = '0;
                    if (n_in <= W'(1))
                    begin
                        res_next   = 1'b0;
                        state_next = S_OUT;
                    end
                    else if (n_in == W'(2))
                    begin
                        res_next   = 1'b1;
                        state_next = S_OUT;
                    end
                    else if (!n_in[0])
                    begin
                        res_next   = 1'b0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_SPLIT;
                    end
                end
            end
            S_SPLIT:
            begin
                if (d_reg[0])
                begin
                    state_next = S_WIT;
                end
                else
                begin
                    d_next = d_reg >> 1;
                    r_next = r_reg + RW'(1);
                end
            end
            S_WIT:
            begin
                if ((32'(k_reg) >= WC) || (w_ext >= n_reg))
                begin
                    res_next   = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    v_next     = W'(1);
                    b_next     = w_ext;
                    e_next     = d_reg;
                    state_next = S_PSTEP;
                end
            end
            S_PSTEP:
            begin
                if (e_reg == '0)
                begin
                    i_next     = '0;
                    state_next = (v_reg == W'(1)) ? S_WIT : S_CHK;
                    if (v_reg == W'(1))
                    begin
                        k_next = k_reg + 4'd1;
                    end
                end
                else if (e_reg[0])
                begin
                    mul_start  = 1'b1;
                    state_next = S_PMULW;
                end
                else
                begin
                    mul_start  = 1'b1;
                    mul_x      = b_reg;
                    state_next = S_PSQW;
                end
            end
            S_PMULW:
            begin
                if (mul_done)
                begin
                    v_next     = mul_prod;
                    state_next = S_PMUL;
                end
            end
            S_PMUL:
            begin
                mul_start  = 1'b1;
                mul_x      = b_reg;
                state_next = S_PSQW;
            end
            S_PSQW:
            begin
                if (mul_done)
                begin
                    b_next     = mul_prod;
                    e_next     = e_reg >> 1;
                    state_next = S_PSQ;
                end
            end
            S_PSQ:
            begin
                state_next = S_PSTEP;
            end
            S_CHK:
            begin
                if (i_reg >= r_reg)
                begin
                    res_next   = 1'b0;
                    state_next = S_OUT;
                end
                else if (v_reg == n_reg - W'(1))
                begin
                    k_next     = k_reg + 4'd1;
                    state_next = S_WIT;
                end
                else
                begin
                    mul_start  = 1'b1;
                    mul_y      = v_reg;
                    state_next = S_SQW;
                end
            end
            S_SQW:
            begin
                if (mul_done)
                begin
                    v_next     = mul_prod;
                    i_next     = i_reg + RW'(1);
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                state_next = S_CHK;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
        b_reg   <= b_next;
        v_reg   <= v_next;
        r_reg   <= r_next;
        i_reg   <= i_next;
        k_reg   <= k_next;
        res_reg <= res_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign is_prime  = res_reg;

    `MR_ASSERT_NOW(a_no_both, out_valid, in_stall, "result shown while accepting")
    `MR_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(is_prime),
        "stalled result changed")
    `MR_ASSERT_NOW(a_mul_idle, mul_start, !mul_busy, "multiply started while busy")
    `MR_ASSERT_NEXT(a_take, in_valid && !in_stall, in_stall, "accept did not stall")
endmodule

### rtl/mrpt_mulmod.sv
`timescale 1ns / 1ps
`include "miller_rabin_prime_test_unit_macros.svh"
module mrpt_mulmod #(
    parameter int W = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] x,
    input  logic [W-1:0] y,
    input  logic [W-1:0] m,
    output logic         busy,
    output logic         done,
    output logic [W-1:0] prod
);
    logic [W-1:0] acc_reg, acc_next;
    logic [W-1:0] x_reg, x_next;
    logic [W-1:0] y_reg, y_next;
    logic [W-1:0] m_reg;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [W-1:0] gap_x, sum_acc, sum_x;

    // add_mod(acc, x) and add_mod(x, x)
    assign gap_x   = m_reg - x_reg;
    assign sum_acc = (acc_reg >= gap_x) ? (acc_reg - gap_x) : (acc_reg + x_reg);
    assign sum_x   = (x_reg >= gap_x) ? (x_reg - gap_x) : (x_reg + x_reg);

    always_comb
    begin
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            x_next    = x;
            y_next    = y;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (y_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                if (y_reg[0])
                begin
                    acc_next = sum_acc;
                end
                x_next = sum_x;
                y_next = y_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        if (start)
        begin
            m_reg <= m;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign prod = acc_reg;

    `MR_ASSERT_NEXT(a_done_after_busy, done_reg, !busy_reg, "done while busy")
    `MR_ASSERT_NOW(a_done_not_busy, done_reg, !busy_reg, "done and busy together")
    `MR_ASSERT_NEXT(a_start_busy, start, busy_reg, "start did not set busy")
endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
    localparam int NUMBER_WIDTH  = 64;
    localparam int WITNESS_COUNT = 13;
    localparam int DRAIN_CYCLES  = 40;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] candidate;
    logic        out_valid;
    logic        out_stall;
    logic        is_prime;

    bit          prime_q[$];
    int          mismatch_count;
    int          items_sent;
    int          results_seen;
    int          primes_seen;
    bit          no_idle;
    int          stall_left;

    miller_rabin_prime_test_unit #(
        .NUMBER_WIDTH (NUMBER_WIDTH),
        .WITNESS_COUNT(WITNESS_COUNT)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .candidate(candidate),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .is_prime (is_prime)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] mul_mod(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] m);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return 64'(p % {64'd0, m});
    endfunction

    function automatic logic [63:0] pow_mod(input logic [63:0] b, input logic [63:0] e,
                                            input logic [63:0] m);
        logic [63:0] acc;
        logic [63:0] base;
        acc  = 64'd1;
        base = b;
        for (int i = 0; i < 64; i++)
        begin
            if (e[i])
                acc = mul_mod(acc, base, m);
            base = mul_mod(base, base, m);
        end
        return acc;
    endfunction

    function automatic bit primality(input logic [63:0] raw);
        logic [63:0] n;
        logic [63:0] d;
        logic [63:0] v;
        logic [63:0] w;
        int          r;
        int          count;
        bit          pass;
        n = raw & ({64{1'b1}} >> (64 - NUMBER_WIDTH));
        if (n <= 64'd1)
            return 1'b0;
        if (n == 64'd2)
            return 1'b1;
        if (!n[0])
            return 1'b0;
        d = n - 64'd1;
        r = 0;
        while (!d[0])
        begin
            d = d >> 1;
            r++;
        end
        count = (WITNESS_COUNT > mrpt_pkg::LIST_LEN) ? mrpt_pkg::LIST_LEN : WITNESS_COUNT;
        for (int k = 0; k < count; k++)
        begin
            w = 64'(mrpt_pkg::witness(4'(k)));
            if (w >= n)
                break;
            v = pow_mod(w, d, n);
            pass = (v == 64'd1);
            for (int i = 0; i < r && !pass; i++)
            begin
                if (v == n - 64'd1)
                    pass = 1'b1;
                else
                    v = mul_mod(v, v, n);
            end
            if (!pass)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic report(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // call at a falling edge; returns at a falling edge
    task automatic send_candidate(input logic [63:0] n);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        candidate <= n;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        prime_q = {prime_q, primality(n)};
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        while (prime_q.size() != 0)
            @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (prime_q.size() == 0)
                report("result with nothing outstanding");
            else
            begin
                if (is_prime !== prime_q[0])
                    report($sformatf("is_prime %b, predicted %b", is_prime, prime_q[0]));
                if (prime_q[0])
                    primes_seen++;
                void'(prime_q.pop_front());
            end
        end
    end

    // hold out_stall for a drawn number of cycles per result
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= no_idle ? 0 : $urandom_range(0, 12);
        end
        else if (out_valid && !out_stall && stall_left == 0)
        begin
            out_stall <= 1'b0;
        end
        else if (out_valid && stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (!out_valid && stall_left == 0)
                stall_left <= no_idle ? 0 : $urandom_range(0, 12);
        end
    end

    task automatic test_edges();
        send_candidate(64'd0);
        send_candidate(64'd1);
        send_candidate(64'd2);
        send_candidate(64'd3);
        send_candidate(64'd4);
        send_candidate(64'd9);
        send_candidate(64'd41);
        send_candidate(64'd43);
        send_candidate(64'd561);
        send_candidate(64'hFFFF_FFFF_FFFF_FFFF);
        send_candidate(64'hFFFF_FFFF_FFFF_FFFE);
        send_candidate(64'hFFFF_FFFF_FFFF_FFC5);
        send_candidate(64'h8000_0000_0000_0000);
    endtask

    task automatic test_pseudoprimes();
        send_candidate(64'd3215031751);
        send_candidate(64'd3825123056546413051);
        send_candidate(64'd2152302898747);
        send_candidate(64'h1FFF_FFFF_FFFF_FFFF);
        send_candidate(64'd4294967291);
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        for (int i = 0; i < 6; i++)
            send_candidate(64'(i * 7 + 5));
        wait_results();
        no_idle = 1'b0;
    endtask

    task automatic test_random(input int count);
        logic [63:0] n;
        int          kind;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(0, 9);
            n = {$urandom, $urandom};
            if (kind < 4)
                n[0] = 1'b0;
            else if (kind < 6)
                n[0] = 1'b1;
            else
                n = 64'($urandom_range(3, 4095) | 1);
            send_candidate(n);
            if (i == count / 2)
                wait_results();
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        candidate      = 64'd0;
        out_stall      = 1'b0;
        no_idle        = 1'b0;
        stall_left     = 0;
        mismatch_count = 0;
        items_sent     = 0;
        results_seen   = 0;
        primes_seen    = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_edges();
        test_pseudoprimes();
        test_back_to_back();
        test_random(76);
        wait_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Tested %0d candidates, %0d results checked, %0d of them prime.",
                 items_sent, results_seen, primes_seen);
        if (mismatch_count == 0 && prime_q.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial
    begin
        #1_000_000_000;
        $display("Timeout with %0d results outstanding.", prime_q.size());
        $display("tb failed");
        $finish;
    end
endmodule
